[src/sha1s_pkg.sv]
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types and constants of the SHA-1 stream hasher: hash constants,
// byte source codes and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1s_pkg;

  typedef logic [31:0] word_t;

  localparam int HASH_WORDS = 5;
  localparam int SCHED_WORDS = 16;

  localparam word_t INIT_HASH [HASH_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  localparam logic [1:0] SEL_DATA = 2'd0;
  localparam logic [1:0] SEL_PAD = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN = 2'd3;

  localparam logic [1:0] STAGE_CH = 2'd0;
  localparam logic [1:0] STAGE_PAR1 = 2'd1;
  localparam logic [1:0] STAGE_MAJ = 2'd2;
  localparam logic [1:0] STAGE_PAR2 = 2'd3;

  typedef struct packed {
    logic       shift;
    logic [1:0] byte_sel;
    logic       count;
    logic       round;
    logic [1:0] stage;
    logic       fold;
    logic       restart;
    logic [2:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       ovf;
  } stat_t;

  typedef struct packed {
    logic [2:0] word_index;
    logic       last_word;
    logic       status;
  } res_info_t;

endpackage

`default_nettype wire

[src/sha1s_if.sv]
// ----------------------------------------------------------------------------
// sha1s request and result channels
// Valid/ready channels carrying request items and digest result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1s_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface sha1s_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        status;

  modport source (output valid, digest_word, word_index, last_word, status, input ready);
  modport sink (input valid, digest_word, word_index, last_word, status, output ready);
endinterface

`default_nettype wire

[src/sha1s_dp.sv]
// ----------------------------------------------------------------------------
// sha1s_dp
// Datapath: byte shift line that doubles as the message schedule, round
// logic, chaining words, fill count and message bit length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sha1s_pkg::cmd_t       cmd,
  input  logic [7:0]            data_byte,
  output sha1s_pkg::stat_t      stat,
  output sha1s_pkg::word_t      hash_word
);

  sha1s_pkg::word_t w [sha1s_pkg::SCHED_WORDS];
  sha1s_pkg::word_t h [sha1s_pkg::HASH_WORDS];
  sha1s_pkg::word_t a, b, c, d, e;
  logic [5:0]       fill;
  logic [63:0]      bit_length;
  logic             ovf;

  logic [7:0]        byte_in;
  logic [7:0][7:0]   len_bytes;
  logic [64:0]       len_sum;
  sha1s_pkg::word_t  sched_new;
  sha1s_pkg::word_t  f_val;
  sha1s_pkg::word_t  t_val;

  assign len_bytes = bit_length;
  assign len_sum = {1'b0, bit_length} + 65'd8;
  assign sched_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                      w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};

  always_comb begin
    unique case (cmd.byte_sel)
      sha1s_pkg::SEL_DATA: byte_in = data_byte;
      sha1s_pkg::SEL_PAD:  byte_in = sha1s_pkg::PAD_BYTE;
      sha1s_pkg::SEL_ZERO: byte_in = 8'h00;
      sha1s_pkg::SEL_LEN:  byte_in = len_bytes[3'd7 - fill[2:0]];
      default:             byte_in = 8'h00;
    endcase
  end

  always_comb begin
    unique case (cmd.stage)
      sha1s_pkg::STAGE_CH:  f_val = (b & c) | (~b & d);
      sha1s_pkg::STAGE_MAJ: f_val = (b & c) | (b & d) | (c & d);
      default:              f_val = b ^ c ^ d;
    endcase
  end

  assign t_val = {a[26:0], a[31:27]} + f_val + e + w[0] + sha1s_pkg::ROUND_K[cmd.stage];

  always_comb begin
    unique case (cmd.word_sel)
      3'd0:    hash_word = h[0];
      3'd1:    hash_word = h[1];
      3'd2:    hash_word = h[2];
      3'd3:    hash_word = h[3];
      3'd4:    hash_word = h[4];
      default: hash_word = '0;
    endcase
  end

  assign stat.fill = fill;
  assign stat.ovf = ovf;

  // schedule / byte shift line
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int j = 0; j < sha1s_pkg::SCHED_WORDS - 1; j++) begin
        w[j] <= {w[j][23:0], w[j+1][31:24]};
      end
      w[sha1s_pkg::SCHED_WORDS-1] <= {w[sha1s_pkg::SCHED_WORDS-1][23:0], byte_in};
    end else if (cmd.round) begin
      for (int j = 0; j < sha1s_pkg::SCHED_WORDS - 1; j++) begin
        w[j] <= w[j+1];
      end
      w[sha1s_pkg::SCHED_WORDS-1] <= sched_new;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.round) begin
      a <= t_val;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end else begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < sha1s_pkg::HASH_WORDS; i++) begin
        h[i] <= sha1s_pkg::INIT_HASH[i];
      end
      fill <= '0;
      bit_length <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.fold) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (cmd.shift) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count) begin
        bit_length <= len_sum[63:0];
        if (len_sum[64]) begin
          ovf <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/sha1s_ctrl.sv]
// ----------------------------------------------------------------------------
// sha1s_ctrl
// Controller: takes requests, sequences padding, the 80 rounds and the
// fold into the chaining words, then hands out the digest words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_type,
  output logic                  req_ready,
  output logic                  res_valid,
  input  logic                  res_ready,
  output sha1s_pkg::res_info_t  res_info,
  output sha1s_pkg::cmd_t       cmd,
  input  sha1s_pkg::stat_t      stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD    = 3'd1;
  localparam logic [2:0] S_ROUND  = 3'd2;
  localparam logic [2:0] S_FOLD   = 3'd3;
  localparam logic [2:0] S_DIGEST = 3'd4;
  localparam logic [2:0] S_ERROR  = 3'd5;

  logic [2:0] state, state_next;
  logic [6:0] rnd, rnd_next;
  logic [2:0] widx, widx_next;
  logic       finishing, finishing_next;
  logic       last_blk, last_blk_next;
  logic       first, first_next;

  always_comb begin
    state_next = state;
    rnd_next = rnd;
    widx_next = widx;
    finishing_next = finishing;
    last_blk_next = last_blk;
    first_next = first;
    cmd = '0;
    cmd.word_sel = widx;
    req_ready = 1'b0;
    res_valid = 1'b0;
    res_info.word_index = widx;
    res_info.last_word = (widx == sha1s_pkg::LAST_WORD_IDX);
    res_info.status = sha1s_pkg::STATUS_OK;

    if (rnd < 7'd20) begin
      cmd.stage = sha1s_pkg::STAGE_CH;
    end else if (rnd < 7'd40) begin
      cmd.stage = sha1s_pkg::STAGE_PAR1;
    end else if (rnd < 7'd60) begin
      cmd.stage = sha1s_pkg::STAGE_MAJ;
    end else begin
      cmd.stage = sha1s_pkg::STAGE_PAR2;
    end

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_type == sha1s_pkg::REQ_APPEND) begin
            if (!stat.ovf) begin
              cmd.shift = 1'b1;
              cmd.byte_sel = sha1s_pkg::SEL_DATA;
              cmd.count = 1'b1;
              if (stat.fill == sha1s_pkg::LAST_FILL) begin
                state_next = S_ROUND;
                rnd_next = '0;
                finishing_next = 1'b0;
              end
            end
          end else if (stat.ovf) begin
            state_next = S_ERROR;
          end else begin
            state_next = S_PAD;
            first_next = 1'b1;
            finishing_next = 1'b1;
            last_blk_next = (stat.fill < sha1s_pkg::LEN_POS);
          end
        end
      end
      S_PAD: begin
        cmd.shift = 1'b1;
        first_next = 1'b0;
        if (first) begin
          cmd.byte_sel = sha1s_pkg::SEL_PAD;
        end else if (last_blk && stat.fill >= sha1s_pkg::LEN_POS) begin
          cmd.byte_sel = sha1s_pkg::SEL_LEN;
        end else begin
          cmd.byte_sel = sha1s_pkg::SEL_ZERO;
        end
        if (stat.fill == sha1s_pkg::LAST_FILL) begin
          state_next = S_ROUND;
          rnd_next = '0;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next = rnd + 7'd1;
        if (rnd == sha1s_pkg::LAST_ROUND) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (!finishing) begin
          state_next = S_IDLE;
        end else if (last_blk) begin
          state_next = S_DIGEST;
          widx_next = '0;
        end else begin
          state_next = S_PAD;
          last_blk_next = 1'b1;
        end
      end
      S_DIGEST: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (widx == sha1s_pkg::LAST_WORD_IDX) begin
            cmd.restart = 1'b1;
            state_next = S_IDLE;
            finishing_next = 1'b0;
          end else begin
            widx_next = widx + 3'd1;
          end
        end
      end
      S_ERROR: begin
        res_valid = 1'b1;
        res_info.word_index = '0;
        res_info.last_word = 1'b1;
        res_info.status = sha1s_pkg::STATUS_TOO_LONG;
        if (res_ready) begin
          cmd.restart = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd <= '0;
      widx <= '0;
      finishing <= 1'b0;
      last_blk <= 1'b0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
      widx <= widx_next;
      finishing <= finishing_next;
      last_blk <= last_blk_next;
      first <= first_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid))
    else $error("request and result sides active together");

  a_fill_zero_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (stat.fill == 6'd0))
    else $error("rounds running on a partly filled block");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (rnd <= sha1s_pkg::LAST_ROUND))
    else $error("round counter out of range");

  a_digest_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGEST) |-> (!stat.ovf && widx <= sha1s_pkg::LAST_WORD_IDX))
    else $error("digest output with overflowed length or bad index");

  a_fold_after_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> ($past(state) == S_ROUND && $past(rnd) == sha1s_pkg::LAST_ROUND))
    else $error("fold without a full set of rounds");
`endif

endmodule

`default_nettype wire

[src/sha1_stream_hasher.sv]
// Append: each byte is shifted into the block while idle; the 64th byte of a block starts the 80 rounds and the fold.
// Finish: the request is accepted, then padding bytes are shifted in up to the block end
//   (one or two blocks), each padded block gets the rounds and the fold, then five result transfers follow.
// Rate is set by the single shared round unit, one round per cycle.
// Reset: synchronous and single-cycle; chaining words, fill count and length are restored.
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream: controller plus shift-line datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher (
  input  logic              clk,
  input  logic              rst,
  sha1s_req_if.sink         req,
  sha1s_res_if.source       res
);

  sha1s_pkg::cmd_t      cmd;
  sha1s_pkg::stat_t     stat;
  sha1s_pkg::res_info_t res_info;
  sha1s_pkg::word_t     hash_word;

  sha1s_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_info  (res_info),
    .cmd       (cmd),
    .stat      (stat)
  );

  sha1s_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (req.data_byte),
    .stat      (stat),
    .hash_word (hash_word)
  );

  // error transfer carries a zero word
  assign res.digest_word = (res_info.status == sha1s_pkg::STATUS_TOO_LONG) ? '0 : hash_word;
  assign res.word_index = res_info.word_index;
  assign res.last_word = res_info.last_word;
  assign res.status = res_info.status;

endmodule

`default_nettype wire
